### rtl/rqa_pkg.sv
// Shared types and constants for the RED queue admission core.
// Register indexes, verdict codes and fixed-point constants; no dependencies.
`default_nettype none
package rqa_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AVG_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PROB   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_RATE  = 3'd5;

    localparam logic [15:0] RST_AVG_WEIGHT = 16'd131;
    localparam logic [23:0] RST_MIN_THRESH = 24'd2500;
    localparam logic [23:0] RST_MAX_THRESH = 24'd7500;
    localparam logic [23:0] RST_LIMIT      = 24'd30000;
    localparam logic [15:0] RST_MAX_PROB   = 16'd6554;
    localparam logic [31:0] RST_IDLE_RATE  = 32'd105;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [23:0] BYTES_MAX = 24'hFFFFFF;
    localparam logic [4:0]  DIV_STEPS = 5'd16;

    typedef enum logic [2:0] {
        V_ACCEPT   = 3'd0,
        V_FULL     = 3'd1,
        V_RANDOM   = 3'd2,
        V_FORCED   = 3'd3,
        V_DEQUEUED = 3'd4,
        V_EMPTY    = 3'd5
    } verdict_t;

endpackage
`default_nettype wire

### rtl/red_queue_admission_core.sv
// Items: a dequeue reads the size store, an empty dequeue records the idle start,
// an idle arrival decays the average by square-and-multiply over the bits of the
// decay exponent, and a band arrival runs up to two 16-step shared divisions.
// Throughput: one item at a time; the next item is taken only once the current
// result is in the output register. Reset clears all control state and loads
// register defaults; the packet-size memory is not cleared.
`default_nettype none
module red_queue_admission_core
    import rqa_pkg::*;
#(
    parameter int FIFO_DEPTH = 256,
    parameter int FRAC_BITS  = 16
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                    in_valid,
    output      logic                    in_stall,
    input  wire logic                    command,
    input  wire logic [15:0]             pkt_bytes,
    input  wire logic [31:0]             now_ticks,
    input  wire logic [15:0]             random_value,
    output      logic                    out_valid,
    input  wire logic                    out_stall,
    output      logic [2:0]              verdict,
    output      logic [15:0]             out_bytes,
    output      logic [23:0]             queue_bytes,
    output      logic [24+FRAC_BITS-1:0] avg_bytes
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int AW = 24 + FRAC_BITS;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_START = 14'b00000000000010,
        S_DEQ   = 14'b00000000000100,
        S_NCALC = 14'b00000000001000,
        S_POW   = 14'b00000000010000,
        S_SCALE = 14'b00000000100000,
        S_EWMA  = 14'b00000001000000,
        S_JUDGE = 14'b00000010000000,
        S_PBDIV = 14'b00000100000000,
        S_DIV   = 14'b00001000000000,
        S_PAMUL = 14'b00010000000000,
        S_PACHK = 14'b00100000000000,
        S_DROP  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic           cmd_reg, cmd_next;
    logic [15:0]    bytes_reg, bytes_next;
    logic [31:0]    now_reg, now_next;
    logic [15:0]    rnd_reg, rnd_next;

    logic [PW-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [23:0]    total_reg, total_next;
    logic [AW-1:0]  avg_reg, avg_next;
    logic [16:0]    mark_reg, mark_next;
    logic [31:0]    idle_reg, idle_next;

    logic [15:0]    w_reg, w_next;
    logic [23:0]    min_reg, min_next, max_reg, max_next, limit_reg, limit_next;
    logic [15:0]    maxp_reg, maxp_next;
    logic [31:0]    rate_reg, rate_next;

    logic [24:0]    tent_reg, tent_next;
    logic           full_reg, full_next;
    logic [63:0]    mul_reg, mul_next;
    logic [47:0]    n_reg, n_next;
    logic [16:0]    pr_reg, pr_next, pb2_reg, pb2_next;
    logic [AW+16:0] p1_reg, p1_next;
    logic [AW+15:0] p2_reg, p2_next;
    logic [AW+15:0] num_reg, num_next;
    logic [AW-1:0]  rem_reg, rem_next, den_reg, den_next;
    logic [15:0]    low_reg, low_next, quo_reg, quo_next;
    logic [4:0]     step_reg, step_next;
    logic           dsel_reg, dsel_next;
    logic [15:0]    pb_reg, pb_next;
    logic [16:0]    pa_reg, pa_next;
    logic [31:0]    prod_reg, prod_next;

    verdict_t       resv_reg, resv_next;
    logic [15:0]    reso_reg, reso_next;

    logic           ov_reg, ov_next;
    verdict_t       ver_reg, ver_next;
    logic [15:0]    ob_reg, ob_next;
    logic [23:0]    qb_reg, qb_next;
    logic [AW-1:0]  ab_reg, ab_next;

    logic [15:0]    fifo_mem [FIFO_DEPTH];
    logic [15:0]    rdata_reg;
    logic           mem_we, mem_re, push;

    logic [AW-1:0]  minf, maxf;
    logic [31:0]    dt;
    logic [24:0]    tent;
    logic [23:0]    sat_s;
    logic [AW-1:0]  sv;
    logic [33:0]    rb, bb;
    logic [AW+16:0] scale;
    logic [AW+17:0] ewsum;
    logic [AW:0]    shifted;
    logic           ge;
    logic [16:0]    dpa;

    assign minf    = {min_reg, {FRAC_BITS{1'b0}}};
    assign maxf    = {max_reg, {FRAC_BITS{1'b0}}};
    assign dt      = now_reg - idle_reg;
    assign tent    = {1'b0, total_reg} + {9'b0, bytes_reg};
    assign sat_s   = tent[24] ? BYTES_MAX : tent[23:0];
    assign sv      = {sat_s, {FRAC_BITS{1'b0}}};
    assign rb      = {17'b0, pr_reg} * {17'b0, pb2_reg};
    assign bb      = {17'b0, pb2_reg} * {17'b0, pb2_reg};
    assign scale   = {17'b0, avg_reg} * {{AW{1'b0}}, pr_reg};
    assign ewsum   = {1'b0, p1_reg} + {2'b0, p2_reg};
    assign shifted = {rem_reg, low_reg[15]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign dpa     = 17'(ONE_Q16 - prod_reg[16:0]);

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign verdict     = ver_reg;
    assign out_bytes   = ob_reg;
    assign queue_bytes = qb_reg;
    assign avg_bytes   = ab_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;   bytes_next = bytes_reg;
        now_next = now_reg;   rnd_next = rnd_reg;
        head_next = head_reg; tail_next = tail_reg; cnt_next = cnt_reg;
        total_next = total_reg; avg_next = avg_reg;
        mark_next = mark_reg; idle_next = idle_reg;
        w_next = w_reg; min_next = min_reg; max_next = max_reg;
        limit_next = limit_reg; maxp_next = maxp_reg; rate_next = rate_reg;
        tent_next = tent_reg; full_next = full_reg; mul_next = mul_reg;
        n_next = n_reg; pr_next = pr_reg; pb2_next = pb2_reg;
        p1_next = p1_reg; p2_next = p2_reg; num_next = num_reg;
        rem_next = rem_reg; den_next = den_reg; low_next = low_reg;
        quo_next = quo_reg; step_next = step_reg; dsel_next = dsel_reg;
        pb_next = pb_reg; pa_next = pa_reg; prod_next = prod_reg;
        resv_next = resv_reg; reso_next = reso_reg;
        ov_next = ov_reg; ver_next = ver_reg; ob_next = ob_reg;
        qb_next = qb_reg; ab_next = ab_reg;
        mem_re = 1'b0;
        push   = 1'b0;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_AVG_WEIGHT: w_next     = cfg_wdata[15:0];
                REG_MIN_THRESH: min_next   = cfg_wdata[23:0];
                REG_MAX_THRESH: max_next   = cfg_wdata[23:0];
                REG_LIMIT:      limit_next = cfg_wdata[23:0];
                REG_MAX_PROB:   maxp_next  = cfg_wdata[15:0];
                REG_IDLE_RATE:  rate_next  = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    bytes_next = pkt_bytes;
                    now_next   = now_ticks;
                    rnd_next   = random_value;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                reso_next = 16'd0;
                tent_next = tent;
                full_next = (cnt_reg >= CW'(FIFO_DEPTH));
                if (cmd_reg)
                begin
                    if (cnt_reg == '0)
                    begin
                        idle_next  = now_reg;
                        resv_next  = V_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_DEQ;
                    end
                end
                else if (total_reg == '0 && cnt_reg < CW'(FIFO_DEPTH))
                begin
                    mul_next   = {32'b0, dt} * {32'b0, rate_reg};
                    state_next = S_NCALC;
                end
                else
                begin
                    p1_next = {17'b0, avg_reg} * {{AW{1'b0}}, 17'(ONE_Q16 - {1'b0, w_reg})};
                    state_next = S_EWMA;
                end
            end
            S_DEQ:
            begin
                reso_next  = rdata_reg;
                head_next  = (head_reg == PW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                total_next = total_reg - {8'b0, rdata_reg};
                resv_next  = V_DEQUEUED;
                state_next = S_DONE;
            end
            S_NCALC:
            begin
                n_next     = mul_reg[63:16];
                pr_next    = ONE_Q16;
                pb2_next   = 17'(ONE_Q16 - {1'b0, w_reg});
                state_next = S_POW;
            end
            S_POW:
            begin
                if (n_reg == '0 || pr_reg == '0)
                    state_next = S_SCALE;
                else
                begin
                    if (n_reg[0])
                        pr_next = rb[32:16];
                    pb2_next = bb[32:16];
                    n_next   = n_reg >> 1;
                end
            end
            S_SCALE:
            begin
                avg_next   = scale[AW+15:16];
                push       = 1'b1;
                resv_next  = V_ACCEPT;
                state_next = S_DONE;
            end
            S_EWMA:
            begin
                if (|ewsum[AW+17:AW+16])
                    avg_next = '1;
                else
                    avg_next = ewsum[AW+15:16];
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                if (full_reg || tent_reg > {1'b0, limit_reg})
                begin
                    mark_next  = '0;
                    resv_next  = V_FULL;
                    state_next = S_DONE;
                end
                else if (minf <= avg_reg && avg_reg <= maxf)
                begin
                    if (mark_reg == '1)
                        mark_next = '0;
                    else if (mark_reg[15:0] != COUNT_MAX)
                        mark_next = mark_reg + 1'b1;
                    if (maxf > minf)
                    begin
                        num_next = {{AW{1'b0}}, maxp_reg} * {16'b0, AW'(avg_reg - minf)};
                        state_next = S_PBDIV;
                    end
                    else
                    begin
                        pb_next    = maxp_reg;
                        state_next = S_PAMUL;
                    end
                end
                else if (avg_reg >= maxf)
                begin
                    mark_next  = '0;
                    resv_next  = V_FORCED;
                    state_next = S_DONE;
                end
                else
                begin
                    mark_next  = '1;
                    push       = 1'b1;
                    resv_next  = V_ACCEPT;
                    state_next = S_DONE;
                end
            end
            S_PBDIV:
            begin
                rem_next   = num_reg[AW+15:16];
                low_next   = num_reg[15:0];
                den_next   = maxf - minf;
                quo_next   = '0;
                step_next  = DIV_STEPS;
                dsel_next  = 1'b0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == '0)
                begin
                    if (dsel_reg)
                    begin
                        pa_next    = {1'b0, quo_reg};
                        state_next = S_DROP;
                    end
                    else
                    begin
                        pb_next    = quo_reg;
                        state_next = S_PAMUL;
                    end
                end
                else
                begin
                    rem_next  = ge ? AW'(shifted - {1'b0, den_reg}) : shifted[AW-1:0];
                    quo_next  = {quo_reg[14:0], ge};
                    low_next  = {low_reg[14:0], 1'b0};
                    step_next = step_reg - 1'b1;
                end
            end
            S_PAMUL:
            begin
                prod_next  = {16'b0, mark_reg[15:0]} * {16'b0, pb_reg};
                state_next = S_PACHK;
            end
            S_PACHK:
            begin
                if (prod_reg >= {15'b0, ONE_Q16} || {1'b0, pb_reg} >= dpa)
                begin
                    pa_next    = ONE_Q16;
                    state_next = S_DROP;
                end
                else
                begin
                    rem_next   = AW'(pb_reg);
                    low_next   = '0;
                    den_next   = AW'(dpa);
                    quo_next   = '0;
                    step_next  = DIV_STEPS;
                    dsel_next  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DROP:
            begin
                if ({1'b0, rnd_reg} < pa_reg)
                begin
                    mark_next = '0;
                    resv_next = V_RANDOM;
                end
                else
                begin
                    push      = 1'b1;
                    resv_next = V_ACCEPT;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ver_next   = resv_reg;
                    ob_next    = reso_reg;
                    qb_next    = total_reg;
                    ab_next    = avg_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (state_reg == S_START && !cmd_reg && !(total_reg == '0 && cnt_reg < CW'(FIFO_DEPTH)))
            p2_next = {16'b0, sv} * {{AW{1'b0}}, w_reg};

        if (push)
        begin
            tail_next  = (tail_reg == PW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            cnt_next   = cnt_reg + 1'b1;
            total_next = total_reg + {8'b0, bytes_reg};
        end
    end

    assign mem_we = push;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            fifo_mem[tail_reg] <= bytes_reg;
        if (mem_re)
            rdata_reg <= fifo_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
            avg_reg   <= '0;
            mark_reg  <= '1;
            idle_reg  <= '0;
            w_reg     <= RST_AVG_WEIGHT;
            min_reg   <= RST_MIN_THRESH;
            max_reg   <= RST_MAX_THRESH;
            limit_reg <= RST_LIMIT;
            maxp_reg  <= RST_MAX_PROB;
            rate_reg  <= RST_IDLE_RATE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            avg_reg   <= avg_next;
            mark_reg  <= mark_next;
            idle_reg  <= idle_next;
            w_reg     <= w_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            limit_reg <= limit_next;
            maxp_reg  <= maxp_next;
            rate_reg  <= rate_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        bytes_reg <= bytes_next;
        now_reg  <= now_next;
        rnd_reg  <= rnd_next;
        tent_reg <= tent_next;
        full_reg <= full_next;
        mul_reg  <= mul_next;
        n_reg    <= n_next;
        pr_reg   <= pr_next;
        pb2_reg  <= pb2_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        dsel_reg <= dsel_next;
        pb_reg   <= pb_next;
        pa_reg   <= pa_next;
        prod_reg <= prod_next;
        resv_reg <= resv_next;
        reso_reg <= reso_next;
        ver_reg  <= ver_next;
        ob_reg   <= ob_next;
        qb_reg   <= qb_next;
        ab_reg   <= ab_next;
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FIFO_DEPTH))
        else $error("entry count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with unequal pointers");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POW |-> pr_reg <= ONE_Q16)
        else $error("decay factor above one");

    a_outb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ver_reg != V_DEQUEUED |-> ob_reg == '0)
        else $error("nonzero size on non-dequeue item");
`endif

endmodule
`default_nettype wire

### bench/tb_red_queue_admission_core.sv
// Testbench for red_queue_admission_core: a directed table, then random enqueue
// and dequeue items, with every result checked against a built-in RED predictor.
// Depends on rqa_pkg and the core RTL only.
module tb_red_queue_admission_core;
    import rqa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 256;
    localparam int AVG_W    = 40;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [2:0]       verdict;
        logic [15:0]      out_bytes;
        logic [23:0]      queue_bytes;
        logic [AVG_W-1:0] avg_bytes;
    } red_result_t;

    // One row of the directed table. has_exp marks rows with a typed-in verdict.
    typedef struct {
        bit          cmd;
        logic [15:0] bytes;
        logic [31:0] now;
        logic [15:0] rnd;
        bit          has_exp;
        logic [2:0]  exp_verdict;
    } red_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  command = 1'b0;
    logic [15:0]           pkt_bytes = '0;
    logic [31:0]           now_ticks = '0;
    logic [15:0]           random_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            verdict;
    logic [15:0]           out_bytes;
    logic [23:0]           queue_bytes;
    logic [AVG_W-1:0]      avg_bytes;

    red_queue_admission_core dut (.*);

    always #4 clk = ~clk;

    // predictor state and configuration
    logic [15:0] w_cfg, maxp_cfg;
    logic [23:0] min_cfg, max_cfg, lim_cfg;
    logic [31:0] rate_cfg;
    logic [15:0] size_mem [DEPTH];
    int unsigned head, tail, entries;
    logic [23:0] total;
    logic [63:0] avg_q;
    int          marks;
    logic [31:0] idle_t;

    red_result_t expected_q[$];
    int          errors, results, drops, dequeues, accepts;
    bit          stall_quiet;
    logic [31:0] clock_now;

    function automatic logic [63:0] pow_decay(logic [63:0] base, logic [63:0] n);
        logic [63:0] r;
        r = 64'h10000;
        while (n != 0 && r != 0) begin
            if (n[0])
                r = (r * base) >> 16;
            base = (base * base) >> 16;
            n = n >> 1;
        end
        return r;
    endfunction

    function automatic void push_size(logic [15:0] b);
        size_mem[tail] = b;
        tail = (tail + 1) % DEPTH;
        entries++;
        total = total + b;
    endfunction

    function automatic logic [2:0] admit(logic [15:0] b, logic [31:0] now,
                                         logic [15:0] rnd);
        logic [63:0] tent, minf, maxf, s, r, pb, pa, prod, n;
        bit full;
        tent = 64'(total) + b;
        full = entries >= DEPTH;
        minf = 64'(min_cfg) << 16;
        maxf = 64'(max_cfg) << 16;
        if (total == 0 && !full) begin
            n = (64'(now - idle_t) * 64'(rate_cfg)) >> 16;
            avg_q = (avg_q * pow_decay(64'h10000 - w_cfg, n)) >> 16;
            push_size(b);
            return V_ACCEPT;
        end
        s = (tent > 64'hFFFFFF ? 64'hFFFFFF : tent) << 16;
        r = (avg_q * (64'h10000 - w_cfg) + s * w_cfg) >> 16;
        avg_q = r > 64'hFF_FFFF_FFFF ? 64'hFF_FFFF_FFFF : r;
        if (full || tent > lim_cfg) begin
            marks = 0;
            return V_FULL;
        end
        if (minf <= avg_q && avg_q <= maxf) begin
            if (marks < 65535)
                marks++;
            pb = (maxf > minf) ? (64'(maxp_cfg) * (avg_q - minf)) / (maxf - minf)
                               : 64'(maxp_cfg);
            prod = 64'(32'(marks)) * pb;
            if (prod >= 64'h10000)
                pa = 64'h10000;
            else begin
                pa = (pb << 16) / (64'h10000 - prod);
                if (pa > 64'h10000)
                    pa = 64'h10000;
            end
            if (64'(rnd) < pa) begin
                marks = 0;
                return V_RANDOM;
            end
            push_size(b);
            return V_ACCEPT;
        end
        if (avg_q >= maxf) begin
            marks = 0;
            return V_FORCED;
        end
        marks = -1;
        push_size(b);
        return V_ACCEPT;
    endfunction

    function automatic red_result_t red_step(bit cmd, logic [15:0] b, logic [31:0] now,
                                             logic [15:0] rnd);
        red_result_t res;
        res.out_bytes = '0;
        if (!cmd)
            res.verdict = admit(b, now, rnd);
        else if (entries == 0) begin
            idle_t = now;
            res.verdict = V_EMPTY;
        end else begin
            res.out_bytes = size_mem[head];
            head = (head + 1) % DEPTH;
            entries--;
            total = total - res.out_bytes;
            res.verdict = V_DEQUEUED;
        end
        res.queue_bytes = total;
        res.avg_bytes = avg_q[AVG_W-1:0];
        return res;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_AVG_WEIGHT: w_cfg = val[15:0];
            REG_MIN_THRESH: min_cfg = val[23:0];
            REG_MAX_THRESH: max_cfg = val[23:0];
            REG_LIMIT:      lim_cfg = val[23:0];
            REG_MAX_PROB:   maxp_cfg = val[15:0];
            REG_IDLE_RATE:  rate_cfg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send(bit cmd, logic [15:0] b, logic [31:0] now, logic [15:0] rnd,
                        bit has_exp, logic [2:0] ev);
        red_result_t res;
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        pkt_bytes <= b;
        now_ticks <= now;
        random_value <= rnd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = red_step(cmd, b, now, rnd);
        if (has_exp && res.verdict != ev)
            report("table verdict", res.verdict, ev);
        expected_q = {expected_q, res};
    endtask

    // sink side
    always @(posedge clk) begin
        red_result_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("unexpected result, verdict %0d", verdict);
                    errors++;
                end else begin
                    e = expected_q[0];
                    expected_q.delete(0);
                    results++;
                    if (verdict == V_DEQUEUED)
                        dequeues++;
                    else if (verdict == V_ACCEPT)
                        accepts++;
                    else if (verdict != V_EMPTY)
                        drops++;
                    if (verdict !== e.verdict)
                        report("verdict", verdict, e.verdict);
                    if (out_bytes !== e.out_bytes)
                        report("out_bytes", out_bytes, e.out_bytes);
                    if (queue_bytes !== e.queue_bytes)
                        report("queue_bytes", queue_bytes, e.queue_bytes);
                    if (avg_bytes !== e.avg_bytes)
                        report("avg_bytes", avg_bytes, e.avg_bytes);
                end
            end
            out_stall <= stall_quiet ? 1'b0 : (gap_len() != 0);
        end
    end

    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout");
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic burst(int count, int max_b, int p_enq);
        bit cmd;
        for (int i = 0; i < count; i++) begin
            cmd = ($urandom_range(0, 99) >= p_enq);
            clock_now = clock_now + $urandom_range(0, 40);
            if ($urandom_range(0, 49) == 0)
                clock_now = $urandom;
            send(cmd, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, max_b)),
                 clock_now, 16'($urandom), 1'b0, '0);
        end
    endtask

    red_row_t table_rows[$];

    initial begin
        errors = 0;
        results = 0;
        drops = 0;
        dequeues = 0;
        accepts = 0;
        stall_quiet = 1'b0;
        clock_now = 0;
        w_cfg = RST_AVG_WEIGHT;
        min_cfg = RST_MIN_THRESH;
        max_cfg = RST_MAX_THRESH;
        lim_cfg = RST_LIMIT;
        maxp_cfg = RST_MAX_PROB;
        rate_cfg = RST_IDLE_RATE;
        head = 0;
        tail = 0;
        entries = 0;
        total = 0;
        avg_q = 0;
        marks = -1;
        idle_t = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        table_rows = '{
            '{1'b1, 16'd0,     32'd100,        16'd0,     1'b1, V_EMPTY},
            '{1'b0, 16'd0,     32'd200,        16'd0,     1'b1, V_ACCEPT},
            '{1'b1, 16'd0,     32'd201,        16'd0,     1'b1, V_DEQUEUED},
            '{1'b0, 16'hFFFF,  32'hFFFF_FFFF,  16'hFFFF,  1'b1, V_ACCEPT},
            '{1'b0, 16'd1,     32'd5,          16'd0,     1'b1, V_FULL},
            '{1'b0, 16'd1000,  32'd6,          16'd0,     1'b0, V_ACCEPT},
            '{1'b1, 16'd0,     32'd7,          16'd0,     1'b1, V_DEQUEUED},
            '{1'b1, 16'd0,     32'd8,          16'd0,     1'b1, V_EMPTY},
            '{1'b1, 16'd0,     32'd9,          16'd0,     1'b1, V_EMPTY},
            '{1'b0, 16'd1500,  32'd0,          16'd0,     1'b1, V_ACCEPT},
            '{1'b0, 16'd1500,  32'd10,         16'h8000,  1'b0, V_ACCEPT},
            '{1'b1, 16'd0,     32'd11,         16'd0,     1'b0, V_ACCEPT},
            '{1'b1, 16'd0,     32'd12,         16'd0,     1'b0, V_ACCEPT}
        };
        foreach (table_rows[i])
            send(table_rows[i].cmd, table_rows[i].bytes, table_rows[i].now,
                 table_rows[i].rnd, table_rows[i].has_exp, table_rows[i].exp_verdict);
        drain();

        // fast weight, tight band: reach probabilistic and forced drops
        cfg_write(REG_AVG_WEIGHT, 32'd65535);
        cfg_write(REG_MIN_THRESH, 32'd1000);
        cfg_write(REG_MAX_THRESH, 32'd3000);
        send(1'b0, 16'd500, 32'd20, 16'd0, 1'b1, V_ACCEPT);
        send(1'b0, 16'd1000, 32'd21, 16'd0, 1'b0, V_ACCEPT);
        send(1'b0, 16'd3000, 32'd22, 16'd0, 1'b1, V_FORCED);
        send(1'b0, 16'd1000, 32'd23, 16'hFFFF, 1'b0, V_ACCEPT);
        send(1'b0, 16'd10, 32'd24, 16'd0, 1'b0, V_ACCEPT);
        drain();

        // equal thresholds, inverted thresholds, extremes of probability
        cfg_write(REG_MAX_PROB, 32'd65535);
        cfg_write(REG_MIN_THRESH, 32'd3000);
        cfg_write(REG_MAX_THRESH, 32'd3000);
        burst(60, 1200, 60);
        drain();
        cfg_write(REG_MIN_THRESH, 32'd5000);
        cfg_write(REG_MAX_THRESH, 32'd1);
        burst(60, 1200, 60);
        drain();
        cfg_write(REG_MAX_PROB, 32'd0);
        cfg_write(REG_MIN_THRESH, 32'd0);
        cfg_write(REG_MAX_THRESH, 32'hFFFFFF);
        cfg_write(REG_LIMIT, 32'hFFFFFF);
        cfg_write(REG_IDLE_RATE, 32'hFFFF_FFFF);
        cfg_write(REG_AVG_WEIGHT, 32'd0);
        burst(80, 65535, 55);
        // fill the size store past its depth
        for (int i = 0; i < 270; i++)
            send(1'b0, 16'($urandom_range(1, 8)), clock_now, 16'($urandom), 1'b0, '0);
        burst(60, 100, 20);
        for (int i = 0; i < 280; i++)
            send(1'b1, 16'($urandom), clock_now, 16'($urandom), 1'b0, '0);
        drain();

        cfg_write(REG_LIMIT, 32'd0);
        cfg_write(REG_IDLE_RATE, 32'd0);
        burst(30, 200, 60);
        drain();

        // default-like settings with the band in play
        cfg_write(REG_AVG_WEIGHT, 32'd4000);
        cfg_write(REG_MIN_THRESH, 32'd2500);
        cfg_write(REG_MAX_THRESH, 32'd7500);
        cfg_write(REG_LIMIT, 32'd30000);
        cfg_write(REG_MAX_PROB, 32'd6554);
        cfg_write(REG_IDLE_RATE, 32'd105);
        burst(500, 1500, 58);
        stall_quiet = 1'b1;
        burst(100, 1500, 60);
        stall_quiet = 1'b0;
        drain();
        cfg_write(REG_AVG_WEIGHT, 32'd20000);
        cfg_write(REG_MAX_PROB, 32'd30000);
        cfg_write(REG_IDLE_RATE, 32'd3000000);
        burst(150, 2000, 55);
        drain();

        $display("covered %0d results: %0d accepts, %0d drops, %0d dequeues",
                 results, accepts, drops, dequeues);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
